// File: rtl/lru_pkg.sv
// Shared constants, types and helpers for the LRU page table.
package lru_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int PAGE_BITS   = 20;
    localparam int CFG_W       = 5;
    localparam int SLOT_W      = 4;
    localparam int STAMP_W     = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [STAMP_W-1:0]   t_stamp;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;  // start of a new lookup
        logic chk;    // read data of one entry is present this cycle
        logic last;   // that entry is the last one in use
    } t_scan_ctl;

    // Outcome of the scan.
    typedef struct packed {
        logic done;
        logic hit;
        t_idx chosen;
    } t_scan_res;

    // Entries in use: zero acts as one, oversize clamps to the built capacity.
    function automatic t_cnt used_entries(logic [CFG_W-1:0] cfg);
        t_cnt n;
        if (cfg == '0) begin
            n = CNT_W'(1);
        end else if (32'(cfg) > 32'(MAX_ENTRIES)) begin
            n = CNT_W'(MAX_ENTRIES);
        end else begin
            n = CNT_W'(cfg);
        end
        return n;
    endfunction

endpackage

// File: rtl/lru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lru_scan.sv
// Scan unit: tag match, first empty entry and oldest stamp, one entry per cycle.
module lru_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lru_pkg::t_scan_ctl i_ctl,
    input  lru_pkg::t_idx     i_idx,
    input  logic              i_entry_valid,
    input  lru_pkg::t_page    i_tag,
    input  lru_pkg::t_stamp   i_stamp,
    input  lru_pkg::t_page    i_page,
    output lru_pkg::t_scan_res o_res
);
    import lru_pkg::*;

    logic   r_have_empty, n_have_empty;
    t_idx   r_empty_idx,  n_empty_idx;
    logic   r_have_min,   n_have_min;
    t_idx   r_min_idx,    n_min_idx;
    t_stamp r_min,        n_min;
    logic   hit_now;

    assign hit_now = i_ctl.chk && i_entry_valid && (i_tag == i_page);

    always_comb begin
        n_have_empty = r_have_empty;
        n_empty_idx  = r_empty_idx;
        n_have_min   = r_have_min;
        n_min_idx    = r_min_idx;
        n_min        = r_min;
        if (i_ctl.chk) begin
            if (!i_entry_valid && !r_have_empty) begin
                n_have_empty = 1'b1;
                n_empty_idx  = i_idx;
            end
            // strict compare keeps the lowest index on equal stamps
            if (i_entry_valid && (!r_have_min || (i_stamp < r_min))) begin
                n_have_min = 1'b1;
                n_min_idx  = i_idx;
                n_min      = i_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_have_empty <= 1'b0;
            r_have_min   <= 1'b0;
        end else begin
            r_have_empty <= n_have_empty;
            r_have_min   <= n_have_min;
        end
        r_empty_idx <= n_empty_idx;
        r_min_idx   <= n_min_idx;
        r_min       <= n_min;
    end

    always_comb begin
        o_res.done = i_ctl.chk && (hit_now || i_ctl.last);
        o_res.hit  = hit_now;
        if (hit_now) begin
            o_res.chosen = i_idx;
        end else if (n_have_empty) begin
            o_res.chosen = n_empty_idx;
        end else begin
            o_res.chosen = n_min_idx;
        end
    end

endmodule

// File: rtl/lru_page_replacement_core.sv
// Top level: sequencer, tag and stamp RAMs, valid bits, counters, output register.
// Sequence: table entries are read and compared one per cycle, then the chosen entry is
//   written, then the result is loaded into the output register; an early hit ends the scan.
// Only one lookup at a time: o_stall is high outside idle, so a new page waits until the
//   result is loaded; a stalled output register holds the sequencer in the load step.
// Reset (synchronous, active low): all entries empty, counters zero, cache_size 16.
// A finished result waits in the output register while the next item is accepted.
module lru_page_replacement_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lru_pkg::CFG_W-1:0]   i_cfg_cache_size,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lru_pkg::PAGE_BITS-1:0] i_page_number,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_fault,
    output logic [lru_pkg::PAGE_BITS-1:0] o_page_out,
    output logic [lru_pkg::SLOT_W-1:0]  o_slot,
    output logic [lru_pkg::STAMP_W-1:0] o_fault_total
);
    import lru_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [CFG_W-1:0]       r_cfg;
    logic [MAX_ENTRIES-1:0] r_valid;
    t_stamp                 r_stamp;
    t_stamp                 r_faults;
    t_page                  r_page;
    t_cnt                   r_issue;
    logic                   r_chk_vld;
    t_idx                   r_chk_idx;
    logic                   r_fault;
    t_idx                   r_chosen;

    logic                   r_o_valid;
    logic                   r_o_fault;
    t_page                  r_o_page;
    logic [SLOT_W-1:0]      r_o_slot;
    t_stamp                 r_o_faults;

    t_cnt                   n_used;
    t_idx                   last_idx;
    logic                   in_xfer;
    logic                   out_xfer;
    logic                   rd_en;
    logic                   wr_en;
    t_page                  tag_rd;
    t_stamp                 stamp_rd;
    t_scan_ctl              scan_ctl;
    t_scan_res              scan_res;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign o_cfg_ready = 1'b1;
    assign n_used      = used_entries(r_cfg);
    assign last_idx    = IDX_W'(n_used - CNT_W'(1));
    assign o_stall     = (r_state != ST_IDLE);
    assign in_xfer     = i_valid && !o_stall;
    assign out_xfer    = r_o_valid && !i_stall;
    assign rd_en       = (r_state == ST_SCAN) && (r_issue < n_used);
    assign wr_en       = (r_state == ST_WRITE);

    assign scan_ctl.clear = in_xfer;
    assign scan_ctl.chk   = (r_state == ST_SCAN) && r_chk_vld;
    assign scan_ctl.last  = (r_chk_idx == last_idx);

    lru_ram #(.WIDTH(PAGE_BITS), .DEPTH(MAX_ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en && r_fault),
        .i_waddr (r_chosen),
        .i_wdata (r_page),
        .i_re    (rd_en),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (tag_rd)
    );

    lru_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_ENTRIES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_chosen),
        .i_wdata (r_stamp),
        .i_re    (rd_en),
        .i_raddr (r_issue[IDX_W-1:0]),
        .o_rdata (stamp_rd)
    );

    lru_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_idx         (r_chk_idx),
        .i_entry_valid (r_valid[r_chk_idx]),
        .i_tag         (tag_rd),
        .i_stamp       (stamp_rd),
        .i_page        (r_page),
        .o_res         (scan_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_xfer) n_state = ST_SCAN;
            ST_SCAN:  if (scan_res.done) n_state = ST_WRITE;
            ST_WRITE: n_state = ST_PUSH;
            ST_PUSH:  if (!r_o_valid || !i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= CFG_RESET;
            r_valid   <= '0;
            r_stamp   <= '0;
            r_faults  <= '0;
            r_chk_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_cache_size;
            end
            r_chk_vld <= rd_en;
            if (wr_en) begin
                r_valid[r_chosen] <= 1'b1;
                r_stamp           <= r_stamp + STAMP_W'(1);
                if (r_fault) begin
                    r_faults <= r_faults + STAMP_W'(1);
                end
            end
            if (r_state == ST_PUSH && (!r_o_valid || !i_stall)) begin
                r_o_valid <= 1'b1;
            end else if (out_xfer) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_page  <= i_page_number;
            r_issue <= '0;
        end else if (rd_en) begin
            r_issue <= r_issue + CNT_W'(1);
        end
        if (rd_en) begin
            r_chk_idx <= r_issue[IDX_W-1:0];
        end
        if (r_state == ST_SCAN && scan_res.done) begin
            r_fault  <= !scan_res.hit;
            r_chosen <= scan_res.chosen;
        end
        if (r_state == ST_PUSH && (!r_o_valid || !i_stall)) begin
            r_o_fault  <= r_fault;
            r_o_page   <= r_page;
            r_o_slot   <= slot_ext[SLOT_W-1:0];
            r_o_faults <= r_faults;
        end
    end

    assign slot_ext = {{SLOT_W{1'b0}}, r_chosen};

    assign o_valid       = r_o_valid;
    assign o_fault       = r_o_fault;
    assign o_page_out    = r_o_page;
    assign o_slot        = r_o_slot;
    assign o_fault_total = r_o_faults;

    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && r_fault) |=> (r_faults == $past(r_faults) + STAMP_W'(1)))
        else $error("fault counter did not advance on a fault");

    a_hit_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && !r_fault) |=> $stable(r_faults))
        else $error("fault counter moved on a hit");

    a_slot_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> (CNT_W'(r_chosen) < n_used))
        else $error("chosen entry outside the entries in use");

    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> r_valid[$past(r_chosen)])
        else $error("written entry not marked valid");

    a_out_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_PUSH))
        else $error("result presented outside the load step");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the LRU page table: directed and random page streams, scored on the fly.
module tb_top;
    import lru_pkg::*;

    typedef struct {
        logic              fault;
        t_page             page;
        logic [SLOT_W-1:0] slot;
        t_stamp            total;
    } t_lookup_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_cache_size = CFG_RESET;
    logic i_valid = 1'b0;
    logic o_stall;
    t_page i_page_number = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_fault;
    t_page o_page_out;
    logic [SLOT_W-1:0] o_slot;
    t_stamp o_fault_total;

    // shadow page table
    t_page      tag_mem   [MAX_ENTRIES];
    logic       tag_valid [MAX_ENTRIES] = '{default: 1'b0};
    t_stamp     use_stamp [MAX_ENTRIES];
    t_stamp     access_cnt = '0;
    t_stamp     fault_cnt = '0;
    logic [CFG_W-1:0] size_reg = CFG_RESET;

    t_page       page_q[$];
    t_lookup_res result_q[$];
    int          n_accepted = 0;
    int          n_err = 0;
    bit          in_xfer = 1'b0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic        quiet;

    // no idling on either side in this window
    assign quiet = (n_accepted >= 700) && (n_accepted < 900);

    lru_page_replacement_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_cache_size (i_cfg_cache_size),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_page_number    (i_page_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_fault          (o_fault),
        .o_page_out       (o_page_out),
        .o_slot           (o_slot),
        .o_fault_total    (o_fault_total)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int entries_in_use(logic [CFG_W-1:0] sz);
        if (sz == '0) begin
            return 1;
        end
        return (int'(sz) > MAX_ENTRIES) ? MAX_ENTRIES : int'(sz);
    endfunction

    function automatic t_lookup_res lookup_page(t_page pg);
        int n;
        int victim;
        bit hit;
        bit got_empty;
        t_lookup_res r;
        n = entries_in_use(size_reg);
        hit = 1'b0;
        got_empty = 1'b0;
        victim = 0;
        for (int i = 0; i < n; i++) begin
            if (!hit && tag_valid[i] && tag_mem[i] == pg) begin
                hit = 1'b1;
                victim = i;
            end
        end
        if (!hit) begin
            fault_cnt = fault_cnt + 1'b1;
            for (int i = 0; i < n; i++) begin
                if (!got_empty && !tag_valid[i]) begin
                    got_empty = 1'b1;
                    victim = i;
                end
            end
            if (!got_empty) begin
                // oldest stamp, lowest index wins ties
                victim = 0;
                for (int i = 1; i < n; i++) begin
                    if (use_stamp[i] < use_stamp[victim]) begin
                        victim = i;
                    end
                end
            end
            tag_mem[victim] = pg;
            tag_valid[victim] = 1'b1;
        end
        use_stamp[victim] = access_cnt;
        access_cnt = access_cnt + 1'b1;
        r.fault = !hit;
        r.page = pg;
        r.slot = SLOT_W'(victim);
        r.total = fault_cnt;
        return r;
    endfunction

    // input side: predict on every accepted transfer
    always @(posedge i_clk) begin
        in_xfer = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            result_q.push_back(lookup_page(i_page_number));
            void'(page_q.pop_front());
            n_accepted++;
            in_xfer = 1'b1;
        end
    end

    // page driver
    always @(negedge i_clk) begin
        if (!i_valid || in_xfer) begin
            if (page_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 18)) begin
                i_valid <= 1'b1;
                i_page_number <= page_q[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stall plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && n_accepted >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(0, 99) < 18);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_lookup_res exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                $error("unexpected result transfer, page_out %h", o_page_out);
                n_err++;
            end else begin
                exp_r = result_q.pop_front();
                if (o_fault !== exp_r.fault) begin
                    $error("fault: expected %0d, got %0d", exp_r.fault, o_fault);
                    n_err++;
                end
                if (o_page_out !== exp_r.page) begin
                    $error("page_out: expected %h, got %h", exp_r.page, o_page_out);
                    n_err++;
                end
                if (o_slot !== exp_r.slot) begin
                    $error("slot: expected %0d, got %0d", exp_r.slot, o_slot);
                    n_err++;
                end
                if (o_fault_total !== exp_r.total) begin
                    $error("fault_total: expected %0d, got %0d", exp_r.total, o_fault_total);
                    n_err++;
                end
            end
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk); while (page_q.size() != 0 || result_q.size() != 0);
    endtask

    task automatic write_size(input int v);
        @(negedge i_clk);
        i_cfg_cache_size <= CFG_W'(v);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        size_reg = CFG_W'(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one phase of random references around a moving working set
    task automatic run_random(input int sz, input int count);
        int n;
        int ws;
        int r;
        t_page base;
        write_size(sz);
        n = entries_in_use(CFG_W'(sz));
        ws = 1;
        base = '0;
        for (int k = 0; k < count; k++) begin
            if (k % 32 == 0) begin
                ws = $urandom_range(1, 2 * n + 3);
                base = t_page'($urandom());
            end
            r = $urandom_range(0, 99);
            if (r < 84) begin
                page_q.push_back(base + t_page'($urandom_range(0, ws - 1)));
            end else if (r < 95) begin
                page_q.push_back(t_page'($urandom()));
            end else if (r < 97) begin
                page_q.push_back('0);
            end else begin
                page_q.push_back('1);
            end
        end
        wait_drained();
    endtask

    initial begin
        int sizes[$];
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset size: fill, then hits on both extremes
        page_q = '{20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h12345};
        wait_drained();

        // two entries: LRU eviction
        write_size(2);
        page_q = '{20'h00000, 20'h00007, 20'hFFFFF, 20'h00007};
        wait_drained();

        // size zero behaves as one entry
        write_size(0);
        page_q = '{20'h00007, 20'h00007};
        wait_drained();

        // oversize clamps; entries above the old size come back
        write_size(31);
        page_q = '{20'h12345, 20'h00007};
        for (int p = 'h100; p <= 'h10C; p++) begin
            page_q.push_back(t_page'(p));
        end
        page_q.push_back(20'h00200);
        wait_drained();

        sizes = '{16, 1, 31, 0, 3, 8, 17, 5, 12, 2};
        sizes.push_back($urandom_range(0, 31));
        sizes.push_back($urandom_range(0, 31));
        foreach (sizes[k]) begin
            run_random(sizes[k], 115);
        end

        // let any stray result show up
        repeat (25) @(posedge i_clk);
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
